FILE: sv/rmq_pkg.sv
package rmq_pkg;

   // default number format: signed Q1.14 in 16 bits
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // which quaternion component comes straight from the root
   typedef logic [1:0] axis_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;
   localparam axis_type AXIS_W = 2'd3;

endpackage

FILE: sv/rotation_matrix_to_quaternion_unit.sv
// Channel  Ports          Payload (low bits first)                    Transfer
// input    req_t*         tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22   tvalid & tready
// result   rsp_t*         tdata: qw qx qy qz; tuser: saturated         tvalid & tready
//
// One matrix per cycle while no result is held. The pipeline runs through the front register,
// the bit-per-stage root with SW = (DATA_WIDTH + FRAC_BITS + 3) / 2 root bits, the
// bit-per-stage divider and the result register.
// Reset is synchronous and clears only the stage valid bits.
// A held result freezes every stage; req_tready drops for as long as it is held.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int W     = DATA_WIDTH,
   localparam int IN_W  = ((9 * W + 7) / 8) * 8,
   localparam int OUT_W = ((4 * W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,   // qw qx qy qz
   output logic             rsp_tuser    // saturated
);

   localparam int RADW  = W + 2 + FRAC_BITS;
   localparam int SW    = (RADW + 1) / 2;
   localparam int QB    = FRAC_BITS + 2;
   localparam int NUM_W = W + 2 + FRAC_BITS;
   localparam int DEN_W = SW + 1;
   localparam int LS    = SW + 1;
   localparam int LD    = QB + 1;
   localparam int NST   = LS + LD + 2;
   localparam int CW    = ((QB + 1 > SW) ? QB + 1 : SW) + 1;
   localparam int S1_W  = 3 * (W + 1) + 3;
   localparam int S2_W  = (SW - 1) + 3;

   localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

   logic                 en;
   logic [NST-1:0]       vld_ff;
   logic signed [W-1:0]  mat [9];

   logic [RADW-1:0]      rad;
   logic signed [W:0]    d0, d1, d2;
   axis_type             axis_f;
   logic                 clamp_f;

   logic [SW-1:0]        root;
   logic signed [W:0]    d0_s, d1_s, d2_s;
   axis_type             axis_s;
   logic                 clamp_s;

   logic [W:0]           mag [3];
   logic [NUM_W-1:0]     num [3];
   logic [DEN_W-1:0]     den;
   logic [QB-1:0]        quo [3];
   logic                 quo_neg [3];

   logic [SW-2:0]        half_d;
   axis_type             axis_d;
   logic                 clamp_d;

   logic signed [CW-1:0] comp [3];
   logic signed [CW-1:0] axv;
   logic signed [CW-1:0] lim [3];
   logic signed [CW-1:0] axl;
   logic                 sat_in;
   logic [W-1:0]         qw_in, qx_in, qy_in, qz_in;
   logic [W-1:0]         qw_ff, qx_ff, qy_ff, qz_ff;
   logic                 sat_ff;

   // whole pipeline moves unless the result register is held
   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   always_comb begin
      for (int n = 0; n < 9; n++) begin
         mat[n] = req_tdata[n*W +: W];
      end
   end

   rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .en       (en),
      .m00      (mat[0]), .m01 (mat[1]), .m02 (mat[2]),
      .m10      (mat[3]), .m11 (mat[4]), .m12 (mat[5]),
      .m20      (mat[6]), .m21 (mat[7]), .m22 (mat[8]),
      .rad_ff   (rad),
      .d0_ff    (d0),
      .d1_ff    (d1),
      .d2_ff    (d2),
      .axis_ff  (axis_f),
      .clamp_ff (clamp_f)
   );

   rmq_sqrt #(.RADW(RADW)) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad),
      .root  (root)
   );

   rmq_delay #(.WIDTH(S1_W), .DEPTH(LS)) u_dly_root (
      .clock (clock),
      .en    (en),
      .din   ({d0, d1, d2, axis_f, clamp_f}),
      .dout  ({d0_s, d1_s, d2_s, axis_s, clamp_s})
   );

   // numerators carry the rounding term, denominator is twice the root
   always_comb begin
      mag[0] = d0_s[W] ? (W+1)'(-d0_s) : (W+1)'(d0_s);
      mag[1] = d1_s[W] ? (W+1)'(-d1_s) : (W+1)'(d1_s);
      mag[2] = d2_s[W] ? (W+1)'(-d2_s) : (W+1)'(d2_s);
      for (int n = 0; n < 3; n++) begin
         num[n] = (NUM_W'(mag[n]) << FRAC_BITS) + NUM_W'(root);
      end
      den = {root, 1'b0};
   end

   rmq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB)) u_div0 (
      .clock (clock), .en (en), .num (num[0]), .den (den), .neg (d0_s[W]),
      .quo (quo[0]), .quo_neg (quo_neg[0])
   );

   rmq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB)) u_div1 (
      .clock (clock), .en (en), .num (num[1]), .den (den), .neg (d1_s[W]),
      .quo (quo[1]), .quo_neg (quo_neg[1])
   );

   rmq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB)) u_div2 (
      .clock (clock), .en (en), .num (num[2]), .den (den), .neg (d2_s[W]),
      .quo (quo[2]), .quo_neg (quo_neg[2])
   );

   rmq_delay #(.WIDTH(S2_W), .DEPTH(LD)) u_dly_div (
      .clock (clock),
      .en    (en),
      .din   ({root[SW-1:1], axis_s, clamp_s}),
      .dout  ({half_d, axis_d, clamp_d})
   );

   // sign, limit to +-1.0 and put components in place
   always_comb begin
      sat_in = clamp_d;
      axv    = CW'(half_d);
      axl    = axv;
      if (axv > ONE) begin
         axl    = ONE;
         sat_in = 1'b1;
      end
      for (int n = 0; n < 3; n++) begin
         comp[n] = quo_neg[n] ? -CW'(quo[n]) : CW'(quo[n]);
         lim[n]  = comp[n];
         if (comp[n] > ONE) begin
            lim[n] = ONE;
            sat_in = 1'b1;
         end else if (comp[n] < -ONE) begin
            lim[n] = -ONE;
            sat_in = 1'b1;
         end
      end
      unique case (axis_d)
         AXIS_W: begin
            qw_in = W'(axl);    qx_in = W'(lim[0]);
            qy_in = W'(lim[1]); qz_in = W'(lim[2]);
         end
         AXIS_X: begin
            qx_in = W'(axl);    qy_in = W'(lim[0]);
            qz_in = W'(lim[1]); qw_in = W'(lim[2]);
         end
         AXIS_Y: begin
            qy_in = W'(axl);    qz_in = W'(lim[0]);
            qx_in = W'(lim[1]); qw_in = W'(lim[2]);
         end
         default: begin
            qz_in = W'(axl);    qx_in = W'(lim[0]);
            qy_in = W'(lim[1]); qw_in = W'(lim[2]);
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (en) begin
         qw_ff  <= qw_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tdata = OUT_W'({qz_ff, qy_ff, qx_ff, qw_ff});
   assign rsp_tuser = sat_ff;

endmodule

FILE: sv/rmq_delay.sv
module rmq_delay import rmq_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // side data shift line, moves with the pipeline enable
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int n = 1; n < DEPTH; n++) begin
            tap_ff[n] <= tap_ff[n-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: sv/rmq_front.sv
module rmq_front import rmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int W    = DATA_WIDTH,
   localparam int RW   = W + 3,
   localparam int RADW = RW - 1 + FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   m00, m01, m02,
   input  logic signed [W-1:0]   m10, m11, m12,
   input  logic signed [W-1:0]   m20, m21, m22,
   output logic [RADW-1:0]       rad_ff,
   output logic signed [W:0]     d0_ff, d1_ff, d2_ff,
   output axis_type              axis_ff,
   output logic                  clamp_ff
);

   localparam logic signed [RW-1:0] ONE = RW'(1) <<< FRAC_BITS;

   logic signed [RW-1:0] trace;
   logic signed [RW-1:0] r;
   logic signed [W:0]    d0_in, d1_in, d2_in;
   logic [RADW-1:0]      rad_in;
   axis_type             axis_in;
   logic                 clamp_in;
   axis_type             pick;

   // branch choice, radicand and the three sums or differences
   always_comb begin
      trace = RW'(m00) + RW'(m11) + RW'(m22);
      pick  = AXIS_X;
      if (m11 > m00) pick = AXIS_Y;
      if (m22 > ((pick == AXIS_Y) ? m11 : m00)) pick = AXIS_Z;

      if (trace > 0) begin
         axis_in = AXIS_W;
         r       = trace + ONE;
         d0_in   = (W+1)'(m21) - (W+1)'(m12);
         d1_in   = (W+1)'(m02) - (W+1)'(m20);
         d2_in   = (W+1)'(m10) - (W+1)'(m01);
      end else if (pick == AXIS_X) begin
         axis_in = AXIS_X;
         r       = RW'(m00) - RW'(m11) - RW'(m22) + ONE;
         d0_in   = (W+1)'(m10) + (W+1)'(m01);
         d1_in   = (W+1)'(m20) + (W+1)'(m02);
         d2_in   = (W+1)'(m21) - (W+1)'(m12);
      end else if (pick == AXIS_Y) begin
         axis_in = AXIS_Y;
         r       = RW'(m11) - RW'(m22) - RW'(m00) + ONE;
         d0_in   = (W+1)'(m21) + (W+1)'(m12);
         d1_in   = (W+1)'(m01) + (W+1)'(m10);
         d2_in   = (W+1)'(m02) - (W+1)'(m20);
      end else begin
         axis_in = AXIS_Z;
         r       = RW'(m22) - RW'(m00) - RW'(m11) + ONE;
         d0_in   = (W+1)'(m02) + (W+1)'(m20);
         d1_in   = (W+1)'(m12) + (W+1)'(m21);
         d2_in   = (W+1)'(m10) - (W+1)'(m01);
      end

      // non-positive radicand: not a rotation, clamp to one LSB
      clamp_in = (r <= 0);
      if (clamp_in) r = RW'(1);
      rad_in = RADW'(r[RW-2:0]) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff   <= rad_in;
         d0_ff    <= d0_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         axis_ff  <= axis_in;
         clamp_ff <= clamp_in;
      end
   end

endmodule

FILE: sv/rmq_sqrt.sv
module rmq_sqrt import rmq_pkg::*; #(
   parameter int RADW = 32,
   localparam int SW  = (RADW + 1) / 2,
   localparam int TW  = 2 * SW + 1
) (
   input  logic            clock,
   input  logic            en,
   input  logic [RADW-1:0] rad,
   output logic [SW-1:0]   root
);

   logic [TW-1:0] rem_ff  [SW+1];
   logic [SW-1:0] root_ff [SW+1];

   // entry register
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= TW'(rad);
         root_ff[0] <= '0;
      end
   end

   // one root bit per stage, most significant first
   for (genvar n = 1; n <= SW; n++) begin : g_stage
      localparam int B = SW - n;
      logic [TW-1:0] test;
      assign test = (TW'(root_ff[n-1]) << (B + 1)) + (TW'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[n-1] >= test) begin
               rem_ff[n]  <= rem_ff[n-1] - test;
               root_ff[n] <= root_ff[n-1] | (SW'(1) << B);
            end else begin
               rem_ff[n]  <= rem_ff[n-1];
               root_ff[n] <= root_ff[n-1];
            end
         end
      end
   end

   assign root = root_ff[SW];

endmodule

FILE: sv/rmq_div.sv
module rmq_div import rmq_pkg::*; #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 17,
   parameter int QB    = 16,
   localparam int XW   = ((NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB) + 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   output logic [QB-1:0]    quo,
   output logic             quo_neg
);

   logic [XW-1:0]    rem_ff [QB+1];
   logic [QB-1:0]    q_ff   [QB+1];
   logic [DEN_W-1:0] den_ff [QB+1];
   logic             neg_ff [QB+1];
   logic             ovf_ff [QB+1];

   // entry: flag quotients too large for QB bits, they saturate later
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= XW'(num);
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         ovf_ff[0] <= XW'(num) >= (XW'(den) << QB);
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar n = 1; n <= QB; n++) begin : g_stage
      localparam int B = QB - n;
      logic [XW-1:0] sub;
      assign sub = XW'(den_ff[n-1]) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[n] <= den_ff[n-1];
            neg_ff[n] <= neg_ff[n-1];
            ovf_ff[n] <= ovf_ff[n-1];
            if (!ovf_ff[n-1] && rem_ff[n-1] >= sub) begin
               rem_ff[n] <= rem_ff[n-1] - sub;
               q_ff[n]   <= q_ff[n-1] | (QB'(1) << B);
            end else begin
               rem_ff[n] <= rem_ff[n-1];
               q_ff[n]   <= q_ff[n-1];
            end
         end
      end
   end

   assign quo     = ovf_ff[QB] ? '1 : q_ff[QB];
   assign quo_neg = neg_ff[QB];

endmodule

FILE: sv/rmq_checker.sv
module rmq_checker import rmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int W     = DATA_WIDTH,
   localparam int IN_W  = ((9 * W + 7) / 8) * 8,
   localparam int OUT_W = ((4 * W + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [IN_W-1:0]  req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   localparam logic signed [W-1:0] ONE  = W'(1) <<< FRAC_BITS;
   localparam logic signed [W-1:0] MONE = -ONE;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // held result keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed");

   // input side stalls only while a result is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output side");

   // every component lies within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[W-1:0]) <= ONE && $signed(rsp_tdata[W-1:0]) >= MONE &&
         $signed(rsp_tdata[2*W-1:W]) <= ONE && $signed(rsp_tdata[2*W-1:W]) >= MONE &&
         $signed(rsp_tdata[3*W-1:2*W]) <= ONE && $signed(rsp_tdata[3*W-1:2*W]) >= MONE &&
         $signed(rsp_tdata[4*W-1:3*W]) <= ONE && $signed(rsp_tdata[4*W-1:3*W]) >= MONE)
      else $error("component beyond unit range");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
   .DATA_WIDTH (DATA_WIDTH),
   .FRAC_BITS  (FRAC_BITS)
) u_rmq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/rotation_matrix_to_quaternion_checker.sv
module rotation_matrix_to_quaternion_checker import rmq_pkg::*; #(
   parameter int W     = 16,
   parameter int FRAC  = 14,
   parameter int IN_W  = 144,
   parameter int OUT_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [OUT_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic         sat;
      logic [W-1:0] qz;
      logic [W-1:0] qy;
      logic [W-1:0] qx;
      logic [W-1:0] qw;
   } quat_t;

   quat_t quat_queue[$];

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // d * 0.5 / root, round half away from zero
   function automatic longint div_root(longint d, longint unsigned s);
      longint unsigned mag, q;
      mag = (d < 0) ? longint'(-d) : d;
      q = ((mag << FRAC) + s) / (s << 1);
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_t matrix_to_quat(logic [IN_W-1:0] data);
      longint m[3][3];
      longint q[4];
      longint one, r, tr;
      longint unsigned s;
      logic flag;
      int i, j, k;
      quat_t res;
      one = longint'(1) << FRAC;
      flag = 0;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            m[a][b] = longint'($signed(data[(a*3+b)*W +: W]));
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         r = tr + one;
         if (r <= 0) begin r = 1; flag = 1; end
         s = isqrt(longint'(r) << FRAC);
         q[3] = s >> 1;
         q[0] = div_root(m[2][1] - m[1][2], s);
         q[1] = div_root(m[0][2] - m[2][0], s);
         q[2] = div_root(m[1][0] - m[0][1], s);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         r = m[i][i] - m[j][j] - m[k][k] + one;
         if (r <= 0) begin r = 1; flag = 1; end
         s = isqrt(longint'(r) << FRAC);
         q[i] = s >> 1;
         q[j] = div_root(m[j][i] + m[i][j], s);
         q[k] = div_root(m[k][i] + m[i][k], s);
         q[3] = div_root(m[k][j] - m[j][k], s);
      end
      for (int n = 0; n < 4; n++) begin
         if (q[n] > one) begin q[n] = one; flag = 1; end
         if (q[n] < -one) begin q[n] = -one; flag = 1; end
      end
      res.qw = q[3][W-1:0];
      res.qx = q[0][W-1:0];
      res.qy = q[1][W-1:0];
      res.qz = q[2][W-1:0];
      res.sat = flag;
      return res;
   endfunction

   assign pending = quat_queue.size();

   // predict on input transfer, compare on result transfer
   always @(posedge clock) begin
      quat_t want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            quat_queue.push_back(matrix_to_quat(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[4*W-1:0]};
            if (quat_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: w/x/y/z/sat exp %h %h %h %h %b got %h %h %h %h %b",
                        want.qw, want.qx, want.qy, want.qz, want.sat,
                        got.qw, got.qx, got.qy, got.qz, got.sat);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/rotation_matrix_to_quaternion_unit_tb.sv
module rotation_matrix_to_quaternion_unit_tb;
   import rmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W     = DATA_WIDTH_DEF;
   localparam int FRAC  = FRAC_BITS_DEF;
   localparam int IN_W  = ((9 * W + 7) / 8) * 8;
   localparam int OUT_W = ((4 * W + 7) / 8) * 8;
   localparam int ONE   = 1 << FRAC;
   localparam int N_RANDOM = 1530;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [OUT_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   int               fail_count;
   int               pending;
   logic             quiet = 0;

   rotation_matrix_to_quaternion_unit u_dut (.*);

   rotation_matrix_to_quaternion_checker #(
      .W(W), .FRAC(FRAC), .IN_W(IN_W), .OUT_W(OUT_W)
   ) u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("rotation_matrix_to_quaternion_unit_tb: errors");
      $finish;
   end

   function automatic logic [IN_W-1:0] pack_matrix(int e[9]);
      logic [IN_W-1:0] d;
      d = '0;
      for (int n = 0; n < 9; n++) d[n*W +: W] = e[n][W-1:0];
      return d;
   endfunction

   function automatic int rand_elem();
      case ($urandom_range(0, 5))
         0: return ONE;
         1: return -ONE;
         2: return $urandom_range(0, 64) - 32;
         3: return $signed(16'($urandom));  // full 16-bit range, off-range too
         default: return int'($urandom_range(0, 2 * ONE)) - ONE;
      endcase
   endfunction

   // near-rotation (permuted, signed axis matrix with jitter), or random elements one time in four
   function automatic logic [IN_W-1:0] rand_matrix();
      int e[9];
      int p, sg;
      if ($urandom_range(0, 3) != 0) begin
         p = $urandom_range(0, 2);
         for (int n = 0; n < 9; n++) e[n] = $urandom_range(0, 600) - 300;
         for (int r = 0; r < 3; r++) begin
            sg = $urandom_range(0, 1) ? ONE - $urandom_range(0, 400)
                                      : -ONE + $urandom_range(0, 400);
            e[r*3 + (r + p) % 3] = sg;
         end
      end else begin
         for (int n = 0; n < 9; n++) e[n] = rand_elem();
      end
      return pack_matrix(e);
   endfunction

   task automatic send(logic [IN_W-1:0] d);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // result side stalls in bursts
   initial begin
      int burst;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_tready <= 0;
         end else begin
            burst = $urandom_range(1, 8);
            rsp_tready <= 1;
         end
         repeat (burst) @(posedge clock);
      end
   end

   initial begin
      int e[9];
      int lim;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // identity and axis flips: trace branch and each axis branch
      e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};           send(pack_matrix(e));
      e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send(pack_matrix(e));
      e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};         send(pack_matrix(e));
      e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};         send(pack_matrix(e));
      // diagonal ties
      e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};        send(pack_matrix(e));
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 send(pack_matrix(e));
      e = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};           send(pack_matrix(e));
      // matrices that are not rotations
      e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};          send(pack_matrix(e));
      e = '{0, ONE, ONE, ONE, -ONE, ONE, ONE, ONE, ONE}; send(pack_matrix(e));
      // saturating components and field extremes
      e = '{ONE, -ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE}; send(pack_matrix(e));
      e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
      send(pack_matrix(e));
      e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
      send(pack_matrix(e));
      e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};        send(pack_matrix(e));
      e = '{1, ONE, -ONE, -ONE, 1, ONE, ONE, -ONE, 1};  send(pack_matrix(e));
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 200) quiet = 1;
         send(rand_matrix());
      end
      req_tvalid <= 0;
      lim = 0;
      while (pending != 0 && lim < 100000) begin
         @(posedge clock);
         lim++;
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("rotation_matrix_to_quaternion_unit_tb: clean");
      end else begin
         $display("rotation_matrix_to_quaternion_unit_tb: errors");
      end
      $finish;
   end
endmodule
